// ----- rtl/core/glpg_pkg.sv -----
// ----------------------------------------------------------------------------
// glpg_pkg
// Shared types and constants for the grid line point generator.
// ----------------------------------------------------------------------------
package glpg_pkg;

  localparam int unsigned GRID_SIZE = 64;
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned DELTA_W   = COORD_W + 1;  // doubled delta, unsigned
  localparam int unsigned ERR_W     = COORD_W + 3;  // signed error term

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

  typedef logic [COORD_W-1:0] coord_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture endpoints, present the start point
    logic step;   // advance to the next point on the line
  } glpg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;   // point on display is the end point
  } glpg_sts_t;

  function automatic coord_t clamp_coord(input coord_t c);
    clamp_coord = (c > COORD_MAX) ? COORD_MAX : c;
  endfunction

endpackage

// ----- rtl/core/grid_line_point_generator_top.sv -----
// ----------------------------------------------------------------------------
// grid_line_point_generator_top
// Bresenham line point generator on a 64x64 grid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one beat per line: the
//   start and end coordinates. Coordinates above GRID_SIZE-1 saturate.
//   Output channel (out_valid_o / out_stall_i) returns one beat per grid
//   point, start to end inclusive, in drawing order; last_point_o marks the
//   end point. Equal endpoints give a single beat with last_point_o set.
// Timing and throughput:
//   The first point is on the output in the cycle after the input beat. Then
//   one point per cycle while the receiver does not stall, so a line gives
//   max(|dx|,|dy|)+1 points (1 to 64). No new line beat is taken until the
//   end point is taken. The single error-term update per step sets the pace.
// Stall: the current point holds on the outputs and stepping pauses.
// Reset: asynchronous, active low; returns to idle with no point pending.
// ----------------------------------------------------------------------------
module grid_line_point_generator_top import glpg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output coord_t point_x_o,
  output coord_t point_y_o,
  output logic   last_point_o
);

  glpg_cmd_t cmd;
  glpg_sts_t sts;

  // sequencing: idle/run, load and step commands
  glpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // point registers double as the output stage
  glpg_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .last_point_o (last_point_o)
  );

endmodule

// ----- rtl/core/glpg_dp.sv -----
// ----------------------------------------------------------------------------
// glpg_dp
// Line stepping datapath: holds the current point, the end point, the
// doubled deltas and the error term; the current point is the output beat.
// ----------------------------------------------------------------------------
module glpg_dp import glpg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  glpg_cmd_t cmd_i,
  output glpg_sts_t sts_o,
  input  coord_t    start_x_i,
  input  coord_t    start_y_i,
  input  coord_t    end_x_i,
  input  coord_t    end_y_i,
  output coord_t    point_x_o,
  output coord_t    point_y_o,
  output logic      last_point_o
);

  coord_t                   x_q, x_d, y_q, y_d;
  coord_t                   xe_q, ye_q;
  logic                     x_neg_q, x_nz_q, y_neg_q, y_nz_q;
  logic                     maj_x_q;
  logic [DELTA_W-1:0]       dmaj_q, dmin_q;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic                     last_q, last_d;

  // load-time values
  coord_t                   x0, y0, xe0, ye0;
  logic signed [COORD_W:0]  ddx, ddy;
  coord_t                   adx, ady;
  logic                     maj_x0;
  coord_t                   amaj, amin;
  logic signed [ERR_W-1:0]  err0;

  // step-time values
  logic                     maj_neg, take_min, mv_x, mv_y;
  coord_t                   x_nxt, y_nxt;
  logic signed [ERR_W-1:0]  err_nxt;

  always_comb begin
    x0  = clamp_coord(start_x_i);
    y0  = clamp_coord(start_y_i);
    xe0 = clamp_coord(end_x_i);
    ye0 = clamp_coord(end_y_i);
    ddx = $signed({1'b0, xe0}) - $signed({1'b0, x0});
    ddy = $signed({1'b0, ye0}) - $signed({1'b0, y0});
    adx = ddx[COORD_W] ? COORD_W'(-ddx) : ddx[COORD_W-1:0];
    ady = ddy[COORD_W] ? COORD_W'(-ddy) : ddy[COORD_W-1:0];
    maj_x0 = (adx >= ady);  // tie goes to x
    amaj   = maj_x0 ? adx : ady;
    amin   = maj_x0 ? ady : adx;
    // 2*|minor| - |major|
    err0 = $signed({2'b00, amin, 1'b0}) - $signed({3'b000, amaj});
  end

  always_comb begin
    maj_neg  = maj_x_q ? x_neg_q : y_neg_q;
    // symmetric rule: on zero error step minor only for positive major dir
    take_min = !err_q[ERR_W-1] && ((err_q != '0) || !maj_neg);
    err_nxt  = err_q + $signed({2'b00, dmin_q})
             - (take_min ? $signed({2'b00, dmaj_q}) : ERR_W'(0));
    mv_x     = x_nz_q && (maj_x_q || take_min);
    mv_y     = y_nz_q && (!maj_x_q || take_min);
    x_nxt    = mv_x ? (x_neg_q ? x_q - coord_t'(1) : x_q + coord_t'(1)) : x_q;
    y_nxt    = mv_y ? (y_neg_q ? y_q - coord_t'(1) : y_q + coord_t'(1)) : y_q;
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    err_d  = err_q;
    last_d = last_q;
    if (cmd_i.load) begin
      x_d    = x0;
      y_d    = y0;
      err_d  = err0;
      last_d = (x0 == xe0) && (y0 == ye0);
    end else if (cmd_i.step) begin
      x_d    = x_nxt;
      y_d    = y_nxt;
      err_d  = err_nxt;
      last_d = maj_x_q ? (x_nxt == xe_q) : (y_nxt == ye_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else begin
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    err_q <= err_d;
    if (cmd_i.load) begin
      xe_q    <= xe0;
      ye_q    <= ye0;
      x_neg_q <= ddx[COORD_W];
      x_nz_q  <= (ddx != '0);
      y_neg_q <= ddy[COORD_W];
      y_nz_q  <= (ddy != '0);
      maj_x_q <= maj_x0;
      dmaj_q  <= {amaj, 1'b0};
      dmin_q  <= {amin, 1'b0};
    end
  end

  assign sts_o.last   = last_q;
  assign point_x_o    = x_q;
  assign point_y_o    = y_q;
  assign last_point_o = last_q;

  // a step always moves one cell along the major axis
  a_major_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (($past(maj_x_q) && x_q != $past(x_q)) ||
                    (!$past(maj_x_q) && y_q != $past(y_q))))
    else $error("major axis did not advance on step");

endmodule

// ----- rtl/core/glpg_ctrl.sv -----
// ----------------------------------------------------------------------------
// glpg_ctrl
// Line controller: idle until a line beat arrives, then emits points until
// the end point has been taken downstream.
// ----------------------------------------------------------------------------
module glpg_ctrl import glpg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output glpg_cmd_t cmd_o,
  input  glpg_sts_t sts_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic in_beat, out_beat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_RUN);
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_beat    = out_valid_o && !out_stall_i;

  assign cmd_o.load = in_beat;
  assign cmd_o.step = out_beat && !sts_i.last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (out_beat && sts_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_shows_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_o)
    else $error("no point after load");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && sts_i.last) |=> (!out_valid_o && !in_stall_o))
    else $error("line did not end after last point");

  a_no_step_past_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> (out_valid_o && !sts_i.last && !cmd_o.load))
    else $error("step issued past end point");

endmodule
